@@ src/lvm_pkg.sv @@
// Shared widths, vector type and fixed-point helpers for the look-at view matrix core.
package lvm_pkg;

  localparam int unsigned FRAC_W  = 30;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DIR_W   = 32;
  localparam int unsigned CROSS_W = 64;
  localparam int unsigned NORM_W  = 31;
  localparam int unsigned RAD_W   = 64;
  localparam int unsigned ROOT_W  = 32;
  localparam int unsigned NUM_W   = 62;
  localparam int unsigned QUO_W   = 31;
  localparam int unsigned RND_W   = 34;

  localparam logic [WORD_W-1:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [63:0]       HALF_Q30  = 64'h0000_0000_2000_0000;
  localparam logic [RND_W-1:0]  NEG_LIMIT = 34'h0_8000_0000;
  localparam logic [RND_W-1:0]  POS_LIMIT = 34'h0_7FFF_FFFF;

  // Element 0 is x, element 2 is z.
  typedef logic [2:0][WORD_W-1:0] vec3_t;

  function automatic logic signed [63:0] smul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p;
  endfunction

  // Magnitude of s divided by 2^30, rounded half away from zero.
  function automatic logic [RND_W-1:0] round_mag(input logic signed [63:0] s);
    logic [63:0] m;
    logic [63:0] t;
    m = s[63] ? $unsigned(-s) : $unsigned(s);
    t = m + HALF_Q30;
    return t[63:FRAC_W];
  endfunction

  function automatic logic [WORD_W-1:0] clamp_unit(input logic signed [63:0] s);
    logic [RND_W-1:0]  m;
    logic [WORD_W-1:0] c;
    m = round_mag(s);
    c = (m > RND_W'(ONE_Q30)) ? ONE_Q30 : m[WORD_W-1:0];
    return s[63] ? WORD_W'(-c) : c;
  endfunction

  function automatic logic [WORD_W-1:0] trans_sat(input logic signed [63:0] s,
                                                  input logic negate);
    logic [RND_W-1:0]  m;
    logic [WORD_W-1:0] lo;
    logic              neg;
    m   = round_mag(s);
    lo  = m[WORD_W-1:0];
    neg = s[63] ^ negate;
    if (m == '0) begin
      return '0;
    end else if (neg) begin
      return (m > NEG_LIMIT) ? 32'h8000_0000 : WORD_W'(-lo);
    end else begin
      return (m > POS_LIMIT) ? 32'h7FFF_FFFF : lo;
    end
  endfunction

endpackage

@@ src/lvm_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module lvm_isqrt
  import lvm_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = ROOT_W;
  localparam int TW    = RAD_W + 2;

  logic [STEPS-1:0]  vld_r, vld_nxt;
  logic [RAD_W-1:0]  rem_r  [STEPS];
  logic [ROOT_W-1:0] root_r [STEPS];
  logic [SIDE_W-1:0] side_r [STEPS];

  assign vld_nxt = {vld_r[STEPS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;
    logic [RAD_W-1:0]  rem_in, rem_nxt;
    logic [ROOT_W-1:0] root_in, root_nxt;
    logic [SIDE_W-1:0] side_in;
    logic [TW-1:0]     trial;

    if (k == 0) begin : g_first
      assign rem_in  = in_rad;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // (root + 2^B)^2 - root^2, with the low bits of root still clear.
    assign trial = (TW'(root_in) << (B + 1)) | (TW'(1) << (2 * B));

    always_comb begin
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (TW'(rem_in) >= trial) begin
        rem_nxt  = RAD_W'(TW'(rem_in) - trial);
        root_nxt = root_in | (ROOT_W'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_root  = root_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

@@ src/lvm_div.sv @@
// Three-lane pipelined restoring divider sharing one divisor, one quotient bit per stage.
module lvm_div
  import lvm_pkg::*;
#(
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [2:0][NUM_W-1:0]  in_num,
  input  logic [ROOT_W-1:0]      in_den,
  input  logic [SIDE_W-1:0]      in_side,
  output logic                   out_valid,
  output logic [2:0][QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0]      out_side
);

  localparam int STEPS = QUO_W;
  localparam int DW    = NUM_W + 1;

  logic [STEPS-1:0]           vld_r, vld_nxt;
  logic [2:0][NUM_W-1:0]      rem_r  [STEPS];
  logic [2:0][QUO_W-1:0]      quo_r  [STEPS];
  logic [ROOT_W-1:0]          den_r  [STEPS];
  logic [SIDE_W-1:0]          side_r [STEPS];

  assign vld_nxt = {vld_r[STEPS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int B = STEPS - 1 - k;
    logic [2:0][NUM_W-1:0] rem_in, rem_nxt;
    logic [2:0][QUO_W-1:0] quo_in, quo_nxt;
    logic [ROOT_W-1:0]     den_in;
    logic [SIDE_W-1:0]     side_in;
    logic [DW-1:0]         dsh;

    if (k == 0) begin : g_first
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign dsh = DW'(den_in) << B;

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int i = 0; i < 3; i++) begin
        if (DW'(rem_in[i]) >= dsh) begin
          rem_nxt[i] = NUM_W'(DW'(rem_in[i]) - dsh);
          quo_nxt[i] = quo_in[i] | (QUO_W'(1) << B);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[STEPS-1];
  assign out_quo   = quo_r[STEPS-1];
  assign out_side  = side_r[STEPS-1];

endmodule

@@ src/lvm_normalize.sv @@
// Pipelined 3-vector normalizer producing a Q2.30 unit vector and a nonzero flag.
module lvm_normalize
  import lvm_pkg::*;
#(
  parameter int IN_W   = DIR_W,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [2:0][IN_W-1:0] in_vec,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_valid,
  output vec3_t                out_vec,
  output logic                 out_nz,
  output logic [SIDE_W-1:0]    out_side
);

  localparam int MSB_W   = $clog2(IN_W);
  localparam int SQ_W    = 2 * NORM_W;
  localparam int ISIDE_W = 3 * NORM_W + 3 + 1 + SIDE_W;
  localparam int DSIDE_W = 3 + 1 + SIDE_W;
  localparam logic [MSB_W-1:0] TOP_BIT = MSB_W'(FRAC_W);

  logic [4:0] vld_r, vld_nxt;
  logic       vld6_r, vld7_r;

  // Stage 1: magnitudes.
  logic [2:0][IN_W-1:0]   mag1_r, mag1_nxt;
  logic [2:0]             neg1_r, neg1_nxt;
  logic [SIDE_W-1:0]      side1_r;
  // Stage 2: leading one of the largest magnitude.
  logic [IN_W-1:0]        mx2;
  logic [2:0][IN_W-1:0]   mag2_r;
  logic [2:0]             neg2_r;
  logic [MSB_W-1:0]       msb2_r, msb2_nxt;
  logic                   nz2_r, nz2_nxt;
  logic [SIDE_W-1:0]      side2_r;
  // Stage 3: scale so the largest lies in [2^30, 2^31).
  logic [IN_W-1:0]        sh3 [3];
  logic [2:0][NORM_W-1:0] a3_r, a3_nxt;
  logic [2:0]             neg3_r;
  logic                   nz3_r;
  logic [SIDE_W-1:0]      side3_r;
  // Stage 4: squares.
  logic [2:0][SQ_W-1:0]   sq4_r, sq4_nxt;
  logic [2:0][NORM_W-1:0] a4_r;
  logic [2:0]             neg4_r;
  logic                   nz4_r;
  logic [SIDE_W-1:0]      side4_r;
  // Stage 5: sum of squares.
  logic [RAD_W-1:0]       rad5_r, rad5_nxt;
  logic [2:0][NORM_W-1:0] a5_r;
  logic [2:0]             neg5_r;
  logic                   nz5_r;
  logic [SIDE_W-1:0]      side5_r;
  // Square root.
  logic                   sq_valid;
  logic [ROOT_W-1:0]      sq_root;
  logic [ISIDE_W-1:0]     sq_side;
  logic [2:0][NORM_W-1:0] a_s;
  logic [2:0]             neg_s;
  logic                   nz_s;
  logic [SIDE_W-1:0]      side_s;
  // Stage 6: rounded numerators.
  logic [2:0][NUM_W-1:0]  num6_r, num6_nxt;
  logic [ROOT_W-1:0]      den6_r;
  logic [2:0]             neg6_r;
  logic                   nz6_r;
  logic [SIDE_W-1:0]      side6_r;
  // Division.
  logic                   dv_valid;
  logic [2:0][QUO_W-1:0]  dv_quo;
  logic [DSIDE_W-1:0]     dv_side;
  logic [2:0]             neg_d;
  logic                   nz_d;
  logic [SIDE_W-1:0]      side_d;
  // Stage 7: clamp and sign.
  logic [WORD_W-1:0]      qc7 [3];
  vec3_t                  vec7_r, vec7_nxt;
  logic                   nz7_r;
  logic [SIDE_W-1:0]      side7_r;

  assign vld_nxt = {vld_r[3:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
    end else if (en) begin
      vld_r  <= vld_nxt;
      vld6_r <= sq_valid;
      vld7_r <= dv_valid;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = in_vec[i][IN_W-1];
      mag1_nxt[i] = neg1_nxt[i] ? IN_W'(~in_vec[i] + 1'b1) : in_vec[i];
    end
  end

  always_comb begin
    mx2 = mag1_r[0];
    if (mag1_r[1] > mx2) mx2 = mag1_r[1];
    if (mag1_r[2] > mx2) mx2 = mag1_r[2];
    nz2_nxt  = |mx2;
    msb2_nxt = '0;
    for (int i = 0; i < IN_W; i++) begin
      if (mx2[i]) msb2_nxt = MSB_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh3[i] = (msb2_r > TOP_BIT) ? (mag2_r[i] >> (msb2_r - TOP_BIT))
                                  : (mag2_r[i] << (TOP_BIT - msb2_r));
      a3_nxt[i] = sh3[i][NORM_W-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq4_nxt[i] = SQ_W'(a3_r[i]) * SQ_W'(a3_r[i]);
    end
  end

  assign rad5_nxt = RAD_W'(sq4_r[0]) + RAD_W'(sq4_r[1]) + RAD_W'(sq4_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      side1_r <= in_side;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      msb2_r  <= msb2_nxt;
      nz2_r   <= nz2_nxt;
      side2_r <= side1_r;
      a3_r    <= a3_nxt;
      neg3_r  <= neg2_r;
      nz3_r   <= nz2_r;
      side3_r <= side2_r;
      sq4_r   <= sq4_nxt;
      a4_r    <= a3_r;
      neg4_r  <= neg3_r;
      nz4_r   <= nz3_r;
      side4_r <= side3_r;
      rad5_r  <= rad5_nxt;
      a5_r    <= a4_r;
      neg5_r  <= neg4_r;
      nz5_r   <= nz4_r;
      side5_r <= side4_r;
    end
  end

  lvm_isqrt #(
    .SIDE_W (ISIDE_W)
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld_r[4]),
    .in_rad    (rad5_r),
    .in_side   ({a5_r, neg5_r, nz5_r, side5_r}),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign {a_s, neg_s, nz_s, side_s} = sq_side;

  // Numerator a * 2^30 + floor(L / 2) gives the rounded quotient.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num6_nxt[i] = (NUM_W'(a_s[i]) << FRAC_W) + NUM_W'(sq_root >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num6_r  <= num6_nxt;
      den6_r  <= sq_root;
      neg6_r  <= neg_s;
      nz6_r   <= nz_s;
      side6_r <= side_s;
    end
  end

  lvm_div #(
    .SIDE_W (DSIDE_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vld6_r),
    .in_num    (num6_r),
    .in_den    (den6_r),
    .in_side   ({neg6_r, nz6_r, side6_r}),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  assign {neg_d, nz_d, side_d} = dv_side;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc7[i] = (WORD_W'(dv_quo[i]) > ONE_Q30) ? ONE_Q30 : WORD_W'(dv_quo[i]);
      vec7_nxt[i] = neg_d[i] ? WORD_W'(-qc7[i]) : qc7[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec7_r  <= vec7_nxt;
      nz7_r   <= nz_d;
      side7_r <= side_d;
    end
  end

  assign out_valid = vld7_r;
  assign out_vec   = vec7_r;
  assign out_nz    = nz7_r;
  assign out_side  = side7_r;

endmodule

@@ src/lvm_frame.sv @@
// True-up cross product, translations and output register of the view matrix.
module lvm_frame
  import lvm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_valid,
  input  vec3_t in_right,
  input  vec3_t in_fwd,
  input  vec3_t in_pos,
  input  logic  in_nz,
  output logic  out_valid,
  output vec3_t out_right,
  output vec3_t out_true_up,
  output vec3_t out_back,
  output vec3_t out_trans
);

  logic [4:0] vld_r, vld_nxt;

  // Stage 1: products.
  logic signed [63:0] rf1_r [6];
  logic signed [63:0] rf1_nxt [6];
  logic signed [63:0] rp1_r [3];
  logic signed [63:0] rp1_nxt [3];
  logic signed [63:0] fp1_r [3];
  logic signed [63:0] fp1_nxt [3];
  vec3_t              r1_r, f1_r, p1_r;
  logic               nz1_r;
  // Stage 2: true up and two dot sums.
  vec3_t              u2_r, u2_nxt;
  logic signed [63:0] dr2_r, dr2_nxt, df2_r, df2_nxt;
  vec3_t              r2_r, f2_r, p2_r;
  logic               nz2_r;
  // Stage 3: true up times position, two translations.
  logic signed [63:0] up3_r [3];
  logic signed [63:0] up3_nxt [3];
  logic [WORD_W-1:0]  tx3_r, tx3_nxt, tz3_r, tz3_nxt;
  vec3_t              r3_r, f3_r, u3_r;
  logic               nz3_r;
  // Stage 4: third dot sum.
  logic signed [63:0] du4_r, du4_nxt;
  logic [WORD_W-1:0]  tx4_r, tz4_r;
  vec3_t              r4_r, f4_r, u4_r;
  logic               nz4_r;
  // Stage 5: output register.
  vec3_t              right5_r, right5_nxt, up5_r, up5_nxt;
  vec3_t              back5_r, back5_nxt, trans5_r, trans5_nxt;

  assign vld_nxt = {vld_r[3:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  always_comb begin
    rf1_nxt[0] = smul(in_right[1], in_fwd[2]);
    rf1_nxt[1] = smul(in_right[2], in_fwd[1]);
    rf1_nxt[2] = smul(in_right[2], in_fwd[0]);
    rf1_nxt[3] = smul(in_right[0], in_fwd[2]);
    rf1_nxt[4] = smul(in_right[0], in_fwd[1]);
    rf1_nxt[5] = smul(in_right[1], in_fwd[0]);
    for (int i = 0; i < 3; i++) begin
      rp1_nxt[i] = smul(in_right[i], in_pos[i]);
      fp1_nxt[i] = smul(in_fwd[i], in_pos[i]);
    end
  end

  always_comb begin
    u2_nxt[0] = clamp_unit(rf1_r[0] - rf1_r[1]);
    u2_nxt[1] = clamp_unit(rf1_r[2] - rf1_r[3]);
    u2_nxt[2] = clamp_unit(rf1_r[4] - rf1_r[5]);
    dr2_nxt   = rp1_r[0] + rp1_r[1] + rp1_r[2];
    df2_nxt   = fp1_r[0] + fp1_r[1] + fp1_r[2];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      up3_nxt[i] = smul(u2_r[i], p2_r[i]);
    end
    tx3_nxt = trans_sat(dr2_r, 1'b1);
    tz3_nxt = trans_sat(df2_r, 1'b0);
  end

  assign du4_nxt = up3_r[0] + up3_r[1] + up3_r[2];

  // A zero direction or an up vector parallel to it clears every entry.
  always_comb begin
    right5_nxt = '0;
    up5_nxt    = '0;
    back5_nxt  = '0;
    trans5_nxt = '0;
    if (nz4_r) begin
      right5_nxt = r4_r;
      up5_nxt    = u4_r;
      for (int i = 0; i < 3; i++) begin
        back5_nxt[i] = WORD_W'(-f4_r[i]);
      end
      trans5_nxt = {tz4_r, trans_sat(du4_r, 1'b1), tx4_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rf1_r    <= rf1_nxt;
      rp1_r    <= rp1_nxt;
      fp1_r    <= fp1_nxt;
      r1_r     <= in_right;
      f1_r     <= in_fwd;
      p1_r     <= in_pos;
      nz1_r    <= in_nz;
      u2_r     <= u2_nxt;
      dr2_r    <= dr2_nxt;
      df2_r    <= df2_nxt;
      r2_r     <= r1_r;
      f2_r     <= f1_r;
      p2_r     <= p1_r;
      nz2_r    <= nz1_r;
      up3_r    <= up3_nxt;
      tx3_r    <= tx3_nxt;
      tz3_r    <= tz3_nxt;
      r3_r     <= r2_r;
      f3_r     <= f2_r;
      u3_r     <= u2_r;
      nz3_r    <= nz2_r;
      du4_r    <= du4_nxt;
      tx4_r    <= tx3_r;
      tz4_r    <= tz3_r;
      r4_r     <= r3_r;
      f4_r     <= f3_r;
      u4_r     <= u3_r;
      nz4_r    <= nz3_r;
      right5_r <= right5_nxt;
      up5_r    <= up5_nxt;
      back5_r  <= back5_nxt;
      trans5_r <= trans5_nxt;
    end
  end

  assign out_valid   = vld_r[4];
  assign out_right   = right5_r;
  assign out_true_up = up5_r;
  assign out_back    = back5_r;
  assign out_trans   = trans5_r;

endmodule

@@ src/lookat_view_matrix_core.sv @@
// Usage notes:
// Right-handed look-at view matrix core. Each input transaction carries a camera
// position (Q16.16) and a viewing direction and reference up vector (Q2.30).
// Each output transaction carries the right, true-up and back rows (Q2.30) and
// the three saturated Q16.16 translations. Both channels use valid/ready.
// Throughput is one transaction per cycle while the output is not stalled; a new
// transaction may follow the previous one in the next cycle. The pipeline holds
// two vector normalizers of 70 stages each (5 setup stages, a
// 32-stage square root, a numerator stage, a 31-stage divider and an output
// stage), 2 cross-product stages and 5 stages for true up and translations.
// The whole pipeline advances together: while out_valid is high and out_ready
// is low, every stage holds and in_ready is low, so nothing is lost or
// repeated. Bubbles travel through the pipeline and are not compacted.
// A zero direction, or an up vector parallel to it, gives all-zero results.
// Synchronous active-low reset clears every valid bit; data registers are not
// reset.
module lookat_view_matrix_core
  import lvm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_up_x,
  input  logic signed [31:0] in_up_y,
  input  logic signed [31:0] in_up_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_right_x,
  output logic signed [31:0] out_right_y,
  output logic signed [31:0] out_right_z,
  output logic signed [31:0] out_true_up_x,
  output logic signed [31:0] out_true_up_y,
  output logic signed [31:0] out_true_up_z,
  output logic signed [31:0] out_back_x,
  output logic signed [31:0] out_back_y,
  output logic signed [31:0] out_back_z,
  output logic signed [31:0] out_trans_x,
  output logic signed [31:0] out_trans_y,
  output logic signed [31:0] out_trans_z
);

  localparam int SIDE1_W = 2 * 3 * WORD_W;
  localparam int SIDE2_W = 2 * 3 * WORD_W + 1;

  logic en;

  vec3_t                 dir_in, pos_in, up_in;
  logic                  n1_valid, n1_nz;
  vec3_t                 n1_vec, n1_pos, n1_up;
  logic [SIDE1_W-1:0]    n1_side;

  logic                  x1_vld_r, x1_vld_nxt, x2_vld_r, x2_vld_nxt;
  logic signed [63:0]    fw_r [6];
  logic signed [63:0]    fw_nxt [6];
  vec3_t                 fx1_r, px1_r, fx2_r, px2_r;
  logic                  nzx1_r, nzx2_r;
  logic [2:0][CROSS_W-1:0] c_r, c_nxt;

  logic                  n2_valid, n2_nz;
  vec3_t                 n2_vec, n2_pos, n2_fwd;
  logic                  n2_nzf;
  logic [SIDE2_W-1:0]    n2_side;

  vec3_t                 fr_right, fr_up, fr_back, fr_trans;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign dir_in = {in_dir_z, in_dir_y, in_dir_x};
  assign pos_in = {in_pos_z, in_pos_y, in_pos_x};
  assign up_in  = {in_up_z, in_up_y, in_up_x};

  lvm_normalize #(
    .IN_W   (DIR_W),
    .SIDE_W (SIDE1_W)
  ) u_norm_dir (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid && en),
    .in_vec    (dir_in),
    .in_side   ({pos_in, up_in}),
    .out_valid (n1_valid),
    .out_vec   (n1_vec),
    .out_nz    (n1_nz),
    .out_side  (n1_side)
  );

  assign {n1_pos, n1_up} = n1_side;

  // Forward cross up, formed exactly.
  always_comb begin
    fw_nxt[0] = smul(n1_vec[1], n1_up[2]);
    fw_nxt[1] = smul(n1_vec[2], n1_up[1]);
    fw_nxt[2] = smul(n1_vec[2], n1_up[0]);
    fw_nxt[3] = smul(n1_vec[0], n1_up[2]);
    fw_nxt[4] = smul(n1_vec[0], n1_up[1]);
    fw_nxt[5] = smul(n1_vec[1], n1_up[0]);
  end

  always_comb begin
    c_nxt[0] = CROSS_W'(fw_r[0] - fw_r[1]);
    c_nxt[1] = CROSS_W'(fw_r[2] - fw_r[3]);
    c_nxt[2] = CROSS_W'(fw_r[4] - fw_r[5]);
  end

  assign x1_vld_nxt = n1_valid;
  assign x2_vld_nxt = x1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_vld_r <= 1'b0;
      x2_vld_r <= 1'b0;
    end else if (en) begin
      x1_vld_r <= x1_vld_nxt;
      x2_vld_r <= x2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fw_r   <= fw_nxt;
      fx1_r  <= n1_vec;
      px1_r  <= n1_pos;
      nzx1_r <= n1_nz;
      c_r    <= c_nxt;
      fx2_r  <= fx1_r;
      px2_r  <= px1_r;
      nzx2_r <= nzx1_r;
    end
  end

  lvm_normalize #(
    .IN_W   (CROSS_W),
    .SIDE_W (SIDE2_W)
  ) u_norm_right (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (x2_vld_r),
    .in_vec    (c_r),
    .in_side   ({px2_r, fx2_r, nzx2_r}),
    .out_valid (n2_valid),
    .out_vec   (n2_vec),
    .out_nz    (n2_nz),
    .out_side  (n2_side)
  );

  assign {n2_pos, n2_fwd, n2_nzf} = n2_side;

  lvm_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (n2_valid),
    .in_right    (n2_vec),
    .in_fwd      (n2_fwd),
    .in_pos      (n2_pos),
    .in_nz       (n2_nz && n2_nzf),
    .out_valid   (out_valid),
    .out_right   (fr_right),
    .out_true_up (fr_up),
    .out_back    (fr_back),
    .out_trans   (fr_trans)
  );

  assign out_right_x   = fr_right[0];
  assign out_right_y   = fr_right[1];
  assign out_right_z   = fr_right[2];
  assign out_true_up_x = fr_up[0];
  assign out_true_up_y = fr_up[1];
  assign out_true_up_z = fr_up[2];
  assign out_back_x    = fr_back[0];
  assign out_back_y    = fr_back[1];
  assign out_back_z    = fr_back[2];
  assign out_trans_x   = fr_trans[0];
  assign out_trans_y   = fr_trans[1];
  assign out_trans_z   = fr_trans[2];

  // A zero right row only comes from a degenerate camera, which clears everything.
  a_degenerate_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_right_x == 0 && out_right_y == 0 && out_right_z == 0) |->
    (out_back_x == 0 && out_back_y == 0 && out_back_z == 0 &&
     out_true_up_x == 0 && out_true_up_y == 0 && out_true_up_z == 0 &&
     out_trans_x == 0 && out_trans_y == 0 && out_trans_z == 0))
    else $error("degenerate camera did not clear all entries");

  a_back_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
    (out_back_x <= 32'sd1073741824 && out_back_x >= -32'sd1073741824 &&
     out_back_y <= 32'sd1073741824 && out_back_y >= -32'sd1073741824 &&
     out_back_z <= 32'sd1073741824 && out_back_z >= -32'sd1073741824))
    else $error("back row outside unit range");

  a_cross_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (en && x1_vld_r) |=> x2_vld_r)
    else $error("cross-product stage dropped a transaction");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(x1_vld_r) && $stable(x2_vld_r)))
    else $error("pipeline moved during a stall");

endmodule
